/* rtl/core/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
`default_nettype none

package lpht_pkg;

    localparam int KeyW    = 16;
    localparam int ValueW  = 32;
    localparam int SizeW   = 8;
    localparam int StatusW = 2;
    localparam int SlotW   = 7;
    localparam int ProbeW  = 8;
    localparam int StepW   = $clog2(KeyW);

    localparam logic [SizeW-1:0] SizeReset = 8'd128;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [StatusW-1:0] ST_INSERTED  = 2'd0;
    localparam logic [StatusW-1:0] ST_FOUND     = 2'd1;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [KeyW-1:0]   key;
        logic [ValueW-1:0] value;
    } t_store_rd;

endpackage

`default_nettype wire

/* rtl/core/linear_probe_hash_table_unit.sv */
// Top level of the linear probing hash table: handshakes, sequencer and result register.
`default_nettype none

// Open addressing hash table with linear probing. Each input item is an insert
// (key plus 32-bit payload) or a lookup of a key, and each item yields exactly
// one result item. The home slot is the key modulo the effective table size
// (the configured size, with zero read as one and values above the capacity
// read as the capacity); probing then steps slot by slot and wraps to slot 0.
// An insert takes the first empty slot or reports the table full after a
// complete pass; a lookup stops on the key, on an empty slot, or after a full
// pass. Duplicate keys are not checked on insert. The block works on one item
// at a time and holds o_stall high while it does. The item first goes to the
// bit-serial remainder unit that forms the home slot, which the sequencer takes
// once the unit is done; each probe then passes through a read state and a
// check state because the slot memory has a registered read port, and an emit
// state hands the result over to the output register. A finished result waits
// in its own output register, so a stalled output does not hold up the next
// item's probing until that next result is ready. Reset empties every slot at
// once through per-slot valid flags; there is no clearing pass. Since the
// table size register is eight bits wide, at most 255 slots can ever be used,
// so storage is sized to the smaller of CAPACITY and 255. The table size
// register should only be written while the block is idle; changing it does
// not rehash entries that are already stored.
module linear_probe_hash_table_unit #(
    parameter int CAPACITY = 128
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration: table size.
    input  wire                            i_cfg_we,
    input  wire [lpht_pkg::SizeW-1:0]      i_cfg_wdata,
    // Input items.
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_kind,
    input  wire [lpht_pkg::KeyW-1:0]       i_key,
    input  wire [lpht_pkg::ValueW-1:0]     i_entry_value,
    // Result items.
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [lpht_pkg::StatusW-1:0]   o_status,
    output logic [lpht_pkg::SlotW-1:0]     o_slot,
    output logic [lpht_pkg::ProbeW-1:0]    o_probe_count,
    output logic [lpht_pkg::ValueW-1:0]    o_found_value
);
    import lpht_pkg::*;

    // Only slots below the largest possible effective size are ever touched.
    localparam int DEPTH = (CAPACITY < 255) ? CAPACITY : 255;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SizeW-1:0] SizeMax = SizeW'(DEPTH);

    // Configuration register.
    logic [SizeW-1:0]    r_table_size;

    // Sequencer and per-item working registers.
    t_state              r_state, n_state;
    logic                r_kind;
    logic [KeyW-1:0]     r_key;
    logic [ValueW-1:0]   r_value;
    logic [SizeW-1:0]    r_size, n_size;
    logic [AW-1:0]       r_pos, n_pos;
    logic [ProbeW-1:0]   r_probes, n_probes;

    // Result waiting to be handed to the output register.
    logic [StatusW-1:0]  r_res_status, n_res_status;
    logic [SlotW-1:0]    r_res_slot, n_res_slot;
    logic [ProbeW-1:0]   r_res_probes, n_res_probes;
    logic [ValueW-1:0]   r_res_value, n_res_value;

    // Output register.
    logic                r_out_valid;
    logic [StatusW-1:0]  r_out_status;
    logic [SlotW-1:0]    r_out_slot;
    logic [ProbeW-1:0]   r_out_probes;
    logic [ValueW-1:0]   r_out_value;

    logic                w_accept;
    logic                w_out_free;
    logic                w_load_out;
    logic                w_div_done;
    logic [SizeW-1:0]    w_remainder;
    logic                w_wr_en;
    logic [SizeW:0]      w_pos_inc;
    t_store_rd           w_rd;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Effective size is fixed for the whole item when it is accepted.
    always_comb begin
        if (r_table_size == '0) begin
            n_size = SizeW'(1);
        end else if (r_table_size > SizeMax) begin
            n_size = SizeMax;
        end else begin
            n_size = r_table_size;
        end
    end

    assign w_pos_inc = (SizeW+1)'(r_pos) + (SizeW+1)'(1);

    lpht_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_dividend  (i_key),
        .i_divisor   (r_size),
        .o_done      (w_div_done),
        .o_remainder (w_remainder)
    );

    lpht_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (r_pos),
        .i_wr_en    (w_wr_en),
        .i_wr_key   (r_key),
        .i_wr_value (r_value),
        .o_rd       (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= SizeReset;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    // Next state, probe walk and result formation.
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_probes     = r_probes;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_probes = r_res_probes;
        n_res_value  = r_res_value;
        w_wr_en      = 1'b0;
        w_load_out   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pos    = w_remainder[AW-1:0];
                    n_probes = ProbeW'(1);
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                // The slot at r_pos is being read; its contents show up next cycle.
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res_probes = r_probes;
                n_res_value  = '0;
                n_res_slot   = '0;
                if (!w_rd.valid) begin
                    n_state = S_EMIT;
                    if (r_kind == KIND_INSERT) begin
                        w_wr_en      = 1'b1;
                        n_res_status = ST_INSERTED;
                        n_res_slot   = SlotW'(r_pos);
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                end else if (r_kind == KIND_LOOKUP && w_rd.key == r_key) begin
                    n_state      = S_EMIT;
                    n_res_status = ST_FOUND;
                    n_res_slot   = SlotW'(r_pos);
                    n_res_value  = w_rd.value;
                end else if (r_probes == r_size) begin
                    // Every slot in use has been examined.
                    n_state      = S_EMIT;
                    n_res_status = (r_kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
                end else begin
                    n_state  = S_READ;
                    n_probes = ProbeW'(r_probes + 1'b1);
                    n_pos    = (w_pos_inc >= {1'b0, r_size}) ? '0 : AW'(w_pos_inc);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_entry_value;
            r_size  <= n_size;
        end
        r_pos        <= n_pos;
        r_probes     <= n_probes;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_probes <= n_res_probes;
        r_res_value  <= n_res_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_probes <= r_res_probes;
            r_out_value  <= r_res_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_probe_count = r_out_probes;
    assign o_found_value = r_out_value;

    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CHECK)
            |-> ((SizeW+1)'(r_pos) < {1'b0, r_size}))
        else $error("probe position outside the table in use");

    a_probes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CHECK)
            |-> (r_probes != '0 && r_probes <= r_size))
        else $error("probe count out of range");

    a_size_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) != S_IDLE) |-> $stable(r_size))
        else $error("effective size changed during an item");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL))
            |-> (o_slot == '0 && o_found_value == '0))
        else $error("miss or full result carries a slot or payload");

endmodule

`default_nettype wire

/* rtl/core/lpht_divider.sv */
// Bit-serial restoring remainder unit: key modulo table size, one bit per cycle.
`default_nettype none

module lpht_divider (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [lpht_pkg::KeyW-1:0]   i_dividend,
    input  wire [lpht_pkg::SizeW-1:0]  i_divisor,
    output logic                       o_done,
    output logic [lpht_pkg::SizeW-1:0] o_remainder
);
    import lpht_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [StepW-1:0]   r_count;
    logic [SizeW-1:0]   r_rem;
    logic [KeyW-1:0]    r_dvd;

    logic [SizeW:0]     w_shift;
    logic [SizeW:0]     w_div_ext;
    logic               w_ge;
    logic [SizeW-1:0]   n_rem;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    assign w_shift   = {r_rem, r_dvd[KeyW-1]};
    assign w_div_ext = {1'b0, i_divisor};
    assign w_ge      = (w_shift >= w_div_ext);
    assign n_rem     = w_ge ? SizeW'(w_shift - w_div_ext) : w_shift[SizeW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= StepW'(r_count + 1'b1);
                if (r_count == StepW'(KeyW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[KeyW-2:0], 1'b0};
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_remainder < i_divisor))
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("done without a running division");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("division restarted while running");

endmodule

`default_nettype wire

/* rtl/core/lpht_store.sv */
// Slot storage: valid flags in flops, keys and payloads in a registered-read memory.
`default_nettype none

module lpht_store #(
    parameter int DEPTH = 128
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire [$clog2(DEPTH)-1:0]     i_addr,
    input  wire                         i_wr_en,
    input  wire [lpht_pkg::KeyW-1:0]    i_wr_key,
    input  wire [lpht_pkg::ValueW-1:0]  i_wr_value,
    output lpht_pkg::t_store_rd         o_rd
);
    import lpht_pkg::*;

    logic [DEPTH-1:0]            r_valid;
    logic [KeyW+ValueW-1:0]      r_mem [DEPTH];
    logic                        r_rd_valid;
    logic [KeyW+ValueW-1:0]      r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_addr];
            if (i_wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= {i_wr_key, i_wr_value};
        end
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.key   = r_rd_data[KeyW+ValueW-1:ValueW];
    assign o_rd.value = r_rd_data[ValueW-1:0];

endmodule

`default_nettype wire
